@@ src/abld_pkg.sv @@
package abld_pkg;

  localparam int ADDR_W   = 4;
  localparam int POS_W    = 18;
  localparam int SIZE_W   = 13;
  localparam int EXP_W    = 19;
  localparam int ROWCOL_W = 9;
  localparam int DIV_W    = 22;
  localparam int QUO_W    = 20;
  localparam int SAT_IN_W = 26;

  localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd8191;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH     = 2'd0,
    REG_FRAME_HEIGHT    = 2'd1,
    REG_SCORE_THRESHOLD = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [15:0]         anchor_number;
    logic [15:0]         score;
    logic [1:0]          level;
    logic                size_sel;
    logic [ROWCOL_W-1:0] column;
    logic [ROWCOL_W-1:0] row;
    logic signed [15:0]  delta_cx;
    logic signed [15:0]  delta_cy;
    logic [EXP_W-1:0]    exp_w;
    logic [EXP_W-1:0]    exp_h;
    logic [59:0]         lm_dx;
    logic [59:0]         lm_dy;
  } rec_t;

  // exp(0.1*(k-16)) in Q16
  function automatic logic [EXP_W-1:0] exp_entry(input logic [5:0] k);
    logic [EXP_W-1:0] v;
    case (k)
      6'd0:  v = 19'd13231;
      6'd1:  v = 19'd14623;
      6'd2:  v = 19'd16161;
      6'd3:  v = 19'd17861;
      6'd4:  v = 19'd19739;
      6'd5:  v = 19'd21815;
      6'd6:  v = 19'd24109;
      6'd7:  v = 19'd26645;
      6'd8:  v = 19'd29447;
      6'd9:  v = 19'd32544;
      6'd10: v = 19'd35967;
      6'd11: v = 19'd39750;
      6'd12: v = 19'd43930;
      6'd13: v = 19'd48550;
      6'd14: v = 19'd53656;
      6'd15: v = 19'd59299;
      6'd16: v = 19'd65536;
      6'd17: v = 19'd72428;
      6'd18: v = 19'd80046;
      6'd19: v = 19'd88464;
      6'd20: v = 19'd97768;
      6'd21: v = 19'd108051;
      6'd22: v = 19'd119414;
      6'd23: v = 19'd131973;
      6'd24: v = 19'd145853;
      6'd25: v = 19'd161193;
      6'd26: v = 19'd178145;
      6'd27: v = 19'd196881;
      6'd28: v = 19'd217587;
      6'd29: v = 19'd240471;
      6'd30: v = 19'd265762;
      6'd31: v = 19'd293712;
      6'd32: v = 19'd324602;
      default: v = 19'd324602;
    endcase
    return v;
  endfunction

  // table lookup with linear interpolation on the low 11 bits
  function automatic logic [EXP_W-1:0] exp_q16(input logic signed [15:0] d);
    logic [15:0]      u;
    logic [EXP_W-1:0] lo;
    logic [EXP_W-1:0] hi;
    logic [14:0]      diff;
    logic [25:0]      prod;
    u    = d ^ 16'h8000;
    lo   = exp_entry({1'b0, u[15:11]});
    hi   = exp_entry({1'b0, u[15:11]} + 6'd1);
    diff = 15'(hi - lo);
    prod = 26'(diff) * 26'(u[10:0]);
    return lo + EXP_W'(prod >> 11);
  endfunction

  // floor(a/5) by reciprocal, exact for a below 2^22
  function automatic logic [QUO_W-1:0] div5(input logic [DIV_W-1:0] a);
    logic [42:0] p;
    p = 43'(a) * 43'd1677722;
    return QUO_W'(p >> 23);
  endfunction

  function automatic logic [POS_W-1:0] sat_pos(input logic signed [SAT_IN_W-1:0] v);
    logic [POS_W-1:0] r;
    if (v > SAT_IN_W'(131071)) begin
      r = 18'h1FFFF;
    end else if (v < -SAT_IN_W'(131072)) begin
      r = 18'h20000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ src/abld_front.sv @@
module abld_front #(
  parameter int MAX_FRAME_DIM = 1024,
  parameter int NUM_LEVELS    = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [10:0]         frame_width,
  input  logic [10:0]         frame_height,
  input  logic [15:0]         score_threshold,
  input  logic                rec_valid,
  output logic                rec_stall,
  input  logic                first_of_frame,
  input  logic [15:0]         face_score,
  input  logic signed [15:0]  delta_cx,
  input  logic signed [15:0]  delta_cy,
  input  logic signed [15:0]  delta_log_w,
  input  logic signed [15:0]  delta_log_h,
  input  logic [59:0]         landmark_dx_packed,
  input  logic [59:0]         landmark_dy_packed,
  input  logic                q_full,
  output logic                q_push,
  output abld_pkg::rec_t      q_data
);

  localparam int CNT_W = $clog2(MAX_FRAME_DIM / 8);
  localparam int LEN_W = CNT_W + 1;
  localparam int DIM_W = $clog2(MAX_FRAME_DIM + 1);

  logic [1:0]       level_select;
  logic [CNT_W-1:0] row_count;
  logic [CNT_W-1:0] column_count;
  logic             size_select;
  logic [15:0]      anchor_count;

  logic [1:0]       level_select_next;
  logic [CNT_W-1:0] row_count_next;
  logic [CNT_W-1:0] column_count_next;
  logic             size_select_next;
  logic [15:0]      anchor_count_next;

  logic [1:0]       cur_level;
  logic [CNT_W-1:0] cur_row;
  logic [CNT_W-1:0] cur_col;
  logic             cur_size;
  logic [15:0]      cur_anchor;

  logic [DIM_W-1:0] dim_w;
  logic [DIM_W-1:0] dim_h;
  logic [DIM_W:0]   sum_w;
  logic [DIM_W:0]   sum_h;
  logic [LEN_W-1:0] len_w;
  logic [LEN_W-1:0] len_h;
  logic [LEN_W-1:0] col_inc;
  logic [LEN_W-1:0] row_inc;
  logic             accept;

  assign rec_stall = q_full;
  assign accept    = rec_valid && !q_full;
  assign q_push    = accept && (face_score >= score_threshold);

  // first_of_frame restarts the anchor walk before this item
  assign cur_level  = first_of_frame ? '0 : level_select;
  assign cur_row    = first_of_frame ? '0 : row_count;
  assign cur_col    = first_of_frame ? '0 : column_count;
  assign cur_size   = first_of_frame ? 1'b0 : size_select;
  assign cur_anchor = first_of_frame ? '0 : anchor_count;

  always_comb begin
    if (frame_width < 11'd8) begin
      dim_w = DIM_W'(8);
    end else if (32'(frame_width) > MAX_FRAME_DIM) begin
      dim_w = DIM_W'(MAX_FRAME_DIM);
    end else begin
      dim_w = DIM_W'(frame_width);
    end
    if (frame_height < 11'd8) begin
      dim_h = DIM_W'(8);
    end else if (32'(frame_height) > MAX_FRAME_DIM) begin
      dim_h = DIM_W'(MAX_FRAME_DIM);
    end else begin
      dim_h = DIM_W'(frame_height);
    end
  end

  // feature map length is ceil(dim / stride)
  assign sum_w = {1'b0, dim_w} + ((DIM_W + 1)'(8) << cur_level) - (DIM_W + 1)'(1);
  assign sum_h = {1'b0, dim_h} + ((DIM_W + 1)'(8) << cur_level) - (DIM_W + 1)'(1);
  assign len_w = LEN_W'(sum_w >> (3 + cur_level));
  assign len_h = LEN_W'(sum_h >> (3 + cur_level));
  assign col_inc = {1'b0, cur_col} + LEN_W'(1);
  assign row_inc = {1'b0, cur_row} + LEN_W'(1);

  always_comb begin
    level_select_next = cur_level;
    row_count_next    = cur_row;
    column_count_next = cur_col;
    size_select_next  = 1'b0;
    anchor_count_next = cur_anchor + 16'd1;
    if (!cur_size) begin
      size_select_next = 1'b1;
    end else if (col_inc < len_w) begin
      column_count_next = col_inc[CNT_W-1:0];
    end else begin
      column_count_next = '0;
      if (row_inc < len_h) begin
        row_count_next = row_inc[CNT_W-1:0];
      end else begin
        row_count_next = '0;
        if (32'(cur_level) + 1 >= NUM_LEVELS) begin
          level_select_next = '0;
          anchor_count_next = '0;
        end else begin
          level_select_next = cur_level + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_select <= '0;
      row_count    <= '0;
      column_count <= '0;
      size_select  <= 1'b0;
      anchor_count <= '0;
    end else if (accept) begin
      level_select <= level_select_next;
      row_count    <= row_count_next;
      column_count <= column_count_next;
      size_select  <= size_select_next;
      anchor_count <= anchor_count_next;
    end
  end

  always_comb begin
    q_data.anchor_number = cur_anchor;
    q_data.score         = face_score;
    q_data.level         = cur_level;
    q_data.size_sel      = cur_size;
    q_data.column        = abld_pkg::ROWCOL_W'(cur_col);
    q_data.row           = abld_pkg::ROWCOL_W'(cur_row);
    q_data.delta_cx      = delta_cx;
    q_data.delta_cy      = delta_cy;
    q_data.exp_w         = abld_pkg::exp_q16(delta_log_w);
    q_data.exp_h         = abld_pkg::exp_q16(delta_log_h);
    q_data.lm_dx         = landmark_dx_packed;
    q_data.lm_dy         = landmark_dy_packed;
  end

endmodule

@@ src/abld_queue.sv @@
module abld_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  abld_pkg::rec_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           avail,
  output abld_pkg::rec_t head
);

  abld_pkg::rec_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ src/abld_back.sv @@
module abld_back #(
  parameter int LANDMARK_COUNT = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                avail,
  input  abld_pkg::rec_t      head,
  output logic                pop,
  output logic                res_valid,
  input  logic                res_stall,
  output logic                item_kind,
  output logic [15:0]         anchor_number,
  output logic [2:0]          point_number,
  output logic signed [17:0]  pos_x,
  output logic signed [17:0]  pos_y,
  output logic [12:0]         box_width,
  output logic [12:0]         box_height,
  output logic [15:0]         out_score,
  output logic                last
);

  logic [2:0] idx;
  logic [2:0] idx_next;
  logic       load;
  logic       is_box;
  logic [2:0] sh;
  logic [2:0] pt;

  logic [9:0]          odd_c;
  logic [9:0]          odd_r;
  logic signed [37:0]  m_x;
  logic signed [37:0]  m_y;
  logic [37:0]         abs_mx;
  logic [37:0]         abs_my;
  logic signed [11:0]  lx;
  logic signed [11:0]  ly;
  logic signed [24:0]  n_x;
  logic signed [24:0]  n_y;
  logic [24:0]         abs_nx;
  logic [24:0]         abs_ny;
  logic                neg_x;
  logic                neg_y;
  logic [abld_pkg::DIV_W-1:0] dv_x;
  logic [abld_pkg::DIV_W-1:0] dv_y;
  logic [abld_pkg::QUO_W-1:0] q_x;
  logic [abld_pkg::QUO_W-1:0] q_y;
  logic signed [abld_pkg::SAT_IN_W-1:0] v_x;
  logic signed [abld_pkg::SAT_IN_W-1:0] v_y;
  logic [abld_pkg::EXP_W-1:0] wpix;
  logic [abld_pkg::EXP_W-1:0] hpix;

  assign load     = avail && (!res_valid || !res_stall);
  assign pop      = load && (32'(idx) == LANDMARK_COUNT);
  assign idx_next = pop ? 3'd0 : idx + 3'd1;
  assign is_box   = (idx == 3'd0);
  assign pt       = is_box ? 3'd0 : idx - 3'd1;
  // anchor size is 16 << sh
  assign sh       = {head.level, 1'b0} + 3'(head.size_sel);
  assign odd_c    = {head.column, 1'b1};
  assign odd_r    = {head.row, 1'b1};

  // box edge numerator: center - size/2, in 1/(5*2^17) pixel units
  assign m_x = ((38'(odd_c) * 38'd5) << (19 + head.level))
             + (38'(head.delta_cx) <<< (8 + sh))
             - (38'(22'(head.exp_w) * 22'd5) << (4 + sh));
  assign m_y = ((38'(odd_r) * 38'd5) << (19 + head.level))
             + (38'(head.delta_cy) <<< (8 + sh))
             - (38'(22'(head.exp_h) * 22'd5) << (4 + sh));
  assign abs_mx = m_x[37] ? 38'(-m_x) : 38'(m_x);
  assign abs_my = m_y[37] ? 38'(-m_y) : 38'(m_y);

  // landmark numerator in tenths of a sixteenth pixel
  assign lx  = head.lm_dx[12 * pt +: 12];
  assign ly  = head.lm_dy[12 * pt +: 12];
  assign n_x = (25'(odd_c * 14'd10) << (6 + head.level)) + (25'(lx) <<< sh);
  assign n_y = (25'(odd_r * 14'd10) << (6 + head.level)) + (25'(ly) <<< sh);
  assign abs_nx = n_x[24] ? 25'(-n_x) : 25'(n_x);
  assign abs_ny = n_y[24] ? 25'(-n_y) : 25'(n_y);

  always_comb begin
    if (is_box) begin
      dv_x  = abld_pkg::DIV_W'(abs_mx >> 17);
      dv_y  = abld_pkg::DIV_W'(abs_my >> 17);
      neg_x = m_x[37];
      neg_y = m_y[37];
    end else begin
      dv_x  = abld_pkg::DIV_W'(abs_nx >> 1);
      dv_y  = abld_pkg::DIV_W'(abs_ny >> 1);
      neg_x = n_x[24];
      neg_y = n_y[24];
    end
  end

  assign q_x = abld_pkg::div5(dv_x);
  assign q_y = abld_pkg::div5(dv_y);

  always_comb begin
    v_x = abld_pkg::SAT_IN_W'(q_x);
    v_y = abld_pkg::SAT_IN_W'(q_y);
    if (is_box) begin
      v_x = v_x <<< 4;
      v_y = v_y <<< 4;
    end
    if (neg_x) begin
      v_x = -v_x;
    end
    if (neg_y) begin
      v_y = -v_y;
    end
  end

  assign wpix = head.exp_w >> (12 - sh);
  assign hpix = head.exp_h >> (12 - sh);

  always_ff @(posedge clk) begin
    if (load) begin
      item_kind     <= !is_box;
      anchor_number <= head.anchor_number;
      point_number  <= pt;
      pos_x         <= abld_pkg::sat_pos(v_x);
      pos_y         <= abld_pkg::sat_pos(v_y);
      box_width     <= !is_box ? '0 :
                       (wpix > 19'(abld_pkg::SIZE_MAX)) ? abld_pkg::SIZE_MAX : wpix[12:0];
      box_height    <= !is_box ? '0 :
                       (hpix > 19'(abld_pkg::SIZE_MAX)) ? abld_pkg::SIZE_MAX : hpix[12:0];
      out_score     <= head.score;
      last          <= (32'(idx) == LANDMARK_COUNT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 3'd0;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= idx_next;
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_last_is_landmark: assert property (@(posedge clk) disable iff (rst)
    res_valid && last |-> item_kind)
    else $error("box item flagged last");

  a_run_holds_head: assert property (@(posedge clk) disable iff (rst)
    idx != 3'd0 |-> avail)
    else $error("landmark run without a queued record");

  a_box_first: assert property (@(posedge clk) disable iff (rst)
    load && is_box |=> res_valid && !item_kind && point_number == 3'd0)
    else $error("run does not open with a box item");

endmodule

@@ src/anchor_box_landmark_decode_top.sv @@
// a passing item is queued; its box result is then registered from the queue head
// a passing item yields a box and LANDMARK_COUNT landmarks in the single output emitter
// failing items yield nothing; a 2-entry queue decouples input and output
// reset (synchronous, rst high) clears the anchor walk, queue and output valid
// registers reset to width 640, height 480, threshold 32768
module anchor_box_landmark_decode_top #(
  parameter int MAX_FRAME_DIM  = 1024,
  parameter int NUM_LEVELS     = 3,
  parameter int LANDMARK_COUNT = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [abld_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                rec_valid,
  output logic                rec_stall,
  input  logic                first_of_frame,
  input  logic [15:0]         face_score,
  input  logic signed [15:0]  delta_cx,
  input  logic signed [15:0]  delta_cy,
  input  logic signed [15:0]  delta_log_w,
  input  logic signed [15:0]  delta_log_h,
  input  logic [59:0]         landmark_dx_packed,
  input  logic [59:0]         landmark_dy_packed,
  output logic                res_valid,
  input  logic                res_stall,
  output logic                item_kind,
  output logic [15:0]         anchor_number,
  output logic [2:0]          point_number,
  output logic signed [17:0]  pos_x,
  output logic signed [17:0]  pos_y,
  output logic [12:0]         box_width,
  output logic [12:0]         box_height,
  output logic [15:0]         out_score,
  output logic                last
);

  logic [10:0] frame_width;
  logic [10:0] frame_height;
  logic [15:0] score_threshold;
  logic        wr_en;

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_avail;
  abld_pkg::rec_t q_in;
  abld_pkg::rec_t q_head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= 11'd640;
      frame_height    <= 11'd480;
      score_threshold <= 16'd32768;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        abld_pkg::REG_FRAME_WIDTH:     frame_width     <= pwdata[10:0];
        abld_pkg::REG_FRAME_HEIGHT:    frame_height    <= pwdata[10:0];
        abld_pkg::REG_SCORE_THRESHOLD: score_threshold <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      abld_pkg::REG_FRAME_WIDTH:     prdata = 32'(frame_width);
      abld_pkg::REG_FRAME_HEIGHT:    prdata = 32'(frame_height);
      abld_pkg::REG_SCORE_THRESHOLD: prdata = 32'(score_threshold);
      default:                       prdata = '0;
    endcase
  end

  abld_front #(
    .MAX_FRAME_DIM(MAX_FRAME_DIM),
    .NUM_LEVELS(NUM_LEVELS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .frame_width(frame_width),
    .frame_height(frame_height),
    .score_threshold(score_threshold),
    .rec_valid(rec_valid),
    .rec_stall(rec_stall),
    .first_of_frame(first_of_frame),
    .face_score(face_score),
    .delta_cx(delta_cx),
    .delta_cy(delta_cy),
    .delta_log_w(delta_log_w),
    .delta_log_h(delta_log_h),
    .landmark_dx_packed(landmark_dx_packed),
    .landmark_dy_packed(landmark_dy_packed),
    .q_full(q_full),
    .q_push(q_push),
    .q_data(q_in)
  );

  abld_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_data(q_in),
    .full(q_full),
    .pop(q_pop),
    .avail(q_avail),
    .head(q_head)
  );

  abld_back #(
    .LANDMARK_COUNT(LANDMARK_COUNT)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .avail(q_avail),
    .head(q_head),
    .pop(q_pop),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .item_kind(item_kind),
    .anchor_number(anchor_number),
    .point_number(point_number),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .box_width(box_width),
    .box_height(box_height),
    .out_score(out_score),
    .last(last)
  );

endmodule

@@ tb/tb_anchor_box_landmark_decode_top.sv @@
module tb_anchor_box_landmark_decode_top;

  typedef struct {
    logic        fof;
    logic [15:0] score;
    logic [15:0] dcx;
    logic [15:0] dcy;
    logic [15:0] dlw;
    logic [15:0] dlh;
    logic [59:0] lmx;
    logic [59:0] lmy;
  } record_t;

  typedef struct {
    logic        kind;
    logic [15:0] anchor;
    logic [2:0]  point;
    logic [17:0] px;
    logic [17:0] py;
    logic [12:0] w;
    logic [12:0] h;
    logic [15:0] score;
    logic        last;
  } decoded_t;

  localparam int EXP_TAB [33] = '{
    13231, 14623, 16161, 17861, 19739, 21815, 24109, 26645,
    29447, 32544, 35967, 39750, 43930, 48550, 53656, 59299,
    65536, 72428, 80046, 88464, 97768, 108051, 119414, 131973,
    145853, 161193, 178145, 196881, 217587, 240471, 265762, 293712,
    324602};
  localparam int ANCHOR_PX [3][2] = '{'{16, 32}, '{64, 128}, '{256, 512}};
  localparam longint UNIT = 40960;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        rec_valid = 1'b0;
  logic        rec_stall;
  logic        first_of_frame = 1'b0;
  logic [15:0] face_score = '0;
  logic signed [15:0] delta_cx = '0;
  logic signed [15:0] delta_cy = '0;
  logic signed [15:0] delta_log_w = '0;
  logic signed [15:0] delta_log_h = '0;
  logic [59:0] landmark_dx_packed = '0;
  logic [59:0] landmark_dy_packed = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        item_kind;
  logic [15:0] anchor_number;
  logic [2:0]  point_number;
  logic signed [17:0] pos_x;
  logic signed [17:0] pos_y;
  logic [12:0] box_width;
  logic [12:0] box_height;
  logic [15:0] out_score;
  logic        last;

  anchor_box_landmark_decode_top dut (.*);

  // predictor copy of registers and anchor walk
  int cfg_width = 640;
  int cfg_height = 480;
  int cfg_thresh = 32768;
  int walk_level, walk_row, walk_col, walk_size, walk_anchor;

  record_t  pending_records[$];
  decoded_t expected_results[$];
  record_t  on_bus;
  int       errors = 0;
  int       boxes_seen = 0;
  int       points_seen = 0;
  int       send_gap = 0;
  int       recv_gap = 0;
  int       hold_request = 0;
  bit       quiet = 1'b0;
  int       cycles = 0;
  int       thr;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int clamp_dim(int d);
    return d < 8 ? 8 : (d > 1024 ? 1024 : d);
  endfunction

  function automatic int cells(int dim, int lv);
    return (clamp_dim(dim) + (8 << lv) - 1) / (8 << lv);
  endfunction

  function automatic longint exp_fix(logic [15:0] d);
    int u, k, f;
    u = int'(d ^ 16'h8000);
    k = (u >> 11) & 31;
    f = u & 2047;
    return longint'(EXP_TAB[k]) + ((longint'(EXP_TAB[k+1] - EXP_TAB[k]) * f) >>> 11);
  endfunction

  function automatic logic [17:0] clip_pos(longint v);
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v[17:0];
  endfunction

  function automatic logic [12:0] clip_size(longint v);
    return v > 8191 ? 13'd8191 : v[12:0];
  endfunction

  function automatic void step_walk();
    walk_size++;
    if (walk_size < 2) begin
      walk_anchor = (walk_anchor + 1) & 16'hFFFF;
      return;
    end
    walk_size = 0;
    walk_col++;
    if (walk_col >= cells(cfg_width, walk_level)) begin
      walk_col = 0;
      walk_row++;
      if (walk_row >= cells(cfg_height, walk_level)) begin
        walk_row = 0;
        walk_level++;
        if (walk_level >= 3) begin
          walk_level = 0;
          walk_anchor = 0;
          return;
        end
      end
    end
    walk_anchor = (walk_anchor + 1) & 16'hFFFF;
  endfunction

  function automatic void decode_record(record_t r);
    longint stride, sz, bx, by, cx, cy, w16, h16, scale, left, top, lx, ly;
    decoded_t e;
    if (r.fof) begin
      walk_level = 0; walk_row = 0; walk_col = 0; walk_size = 0; walk_anchor = 0;
    end
    if (int'(r.score) >= cfg_thresh) begin
      stride = 8 << walk_level;
      sz = ANCHOR_PX[walk_level][walk_size];
      bx = (2 * longint'(walk_col) + 1) * stride * (UNIT / 2);
      by = (2 * longint'(walk_row) + 1) * stride * (UNIT / 2);
      cx = bx + longint'($signed(r.dcx)) * sz;
      cy = by + longint'($signed(r.dcy)) * sz;
      w16 = sz * exp_fix(r.dlw);
      h16 = sz * exp_fix(r.dlh);
      scale = UNIT * 65536;
      left = (cx * 65536 - w16 * (UNIT / 2)) / scale;
      top = (cy * 65536 - h16 * (UNIT / 2)) / scale;
      e = '{1'b0, walk_anchor[15:0], 3'd0, clip_pos(left * 16), clip_pos(top * 16),
            clip_size(w16 >>> 16), clip_size(h16 >>> 16), r.score, 1'b0};
      expected_results.insert(expected_results.size(), e);
      for (int p = 0; p < 5; p++) begin
        lx = longint'($signed(r.lmx[12*p +: 12]));
        ly = longint'($signed(r.lmy[12*p +: 12]));
        e = '{1'b1, walk_anchor[15:0], 3'(p), clip_pos((bx + lx * 16 * sz) / (UNIT / 16)),
              clip_pos((by + ly * 16 * sz) / (UNIT / 16)), 13'd0, 13'd0, r.score,
              p == 4};
        expected_results.insert(expected_results.size(), e);
      end
    end
    step_walk();
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else begin
      if (rec_valid && !rec_stall) decode_record(on_bus);
      if (!(rec_valid && rec_stall)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          rec_valid <= 1'b0;
        end else if (pending_records.size() > 0) begin
          on_bus = pending_records.pop_front();
          first_of_frame <= on_bus.fof;
          face_score <= on_bus.score;
          delta_cx <= on_bus.dcx;
          delta_cy <= on_bus.dcy;
          delta_log_w <= on_bus.dlw;
          delta_log_h <= on_bus.dlh;
          landmark_dx_packed <= on_bus.lmx;
          landmark_dy_packed <= on_bus.lmy;
          rec_valid <= 1'b1;
          if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 16);
        end else begin
          rec_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // receiver
  always @(posedge clk) begin
    decoded_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, anchor", anchor_number, -1);
        end else begin
          e = expected_results.pop_front();
          if (item_kind) points_seen++; else boxes_seen++;
          if (item_kind !== e.kind) report_mismatch("item_kind", item_kind, e.kind);
          if (anchor_number !== e.anchor)
            report_mismatch("anchor_number", anchor_number, e.anchor);
          if (point_number !== e.point) report_mismatch("point_number", point_number, e.point);
          if (pos_x !== e.px) report_mismatch("pos_x", pos_x, $signed(e.px));
          if (pos_y !== e.py) report_mismatch("pos_y", pos_y, $signed(e.py));
          if (box_width !== e.w) report_mismatch("box_width", box_width, e.w);
          if (box_height !== e.h) report_mismatch("box_height", box_height, e.h);
          if (out_score !== e.score) report_mismatch("out_score", out_score, e.score);
          if (last !== e.last) report_mismatch("last", last, e.last);
        end
      end
      if (hold_request > 0) begin
        recv_gap = hold_request;
        hold_request = 0;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        res_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 15);
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(abld_pkg::reg_index_t idx, int value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      abld_pkg::REG_FRAME_WIDTH: cfg_width = value & 11'h7FF;
      abld_pkg::REG_FRAME_HEIGHT: cfg_height = value & 11'h7FF;
      default: cfg_thresh = value & 16'hFFFF;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_records.size() > 0 || rec_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [59:0] rand60();
    return 60'({$urandom(), $urandom()});
  endfunction

  function automatic void queue_record(logic fof, logic [15:0] sc, logic [15:0] cxd,
                                       logic [15:0] cyd, logic [15:0] wd, logic [15:0] hd,
                                       logic [59:0] lx, logic [59:0] ly);
    record_t r;
    r = '{fof, sc, cxd, cyd, wd, hd, lx, ly};
    pending_records.insert(pending_records.size(), r);
  endfunction

  // mostly passing scores, with the random fields spanning every bit
  task automatic queue_random(int n);
    logic [15:0] sc;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) != 0) sc = 16'($urandom_range(thr, 65535));
      else sc = 16'($urandom());
      queue_record($urandom_range(0, 24) == 0, sc, 16'($urandom()), 16'($urandom()),
                   16'($urandom()), 16'($urandom()), rand60(), rand60());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    walk_level = 0; walk_row = 0; walk_col = 0; walk_size = 0; walk_anchor = 0;

    // directed part at reset settings
    queue_record(1'b1, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, '1, '1);
    queue_record(1'b0, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, '0, '0);
    queue_record(1'b0, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                 {5{12'h800}}, {5{12'h7FF}});
    queue_record(1'b0, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, '1, '0);
    queue_record(1'b0, 16'h8001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, '0, '1);
    queue_record(1'b0, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h07FF, 16'h0800,
                 {5{12'h001}}, {5{12'hFFF}});
    queue_record(1'b1, 16'hC000, 16'h1234, 16'hEDCB, 16'hF800, 16'h7800,
                 rand60(), rand60());
    wait_drained();

    // tiny frame, every record passes, counter wraps across all levels
    write_reg(abld_pkg::REG_FRAME_WIDTH, 8);
    write_reg(abld_pkg::REG_FRAME_HEIGHT, 8);
    write_reg(abld_pkg::REG_SCORE_THRESHOLD, 0);
    thr = 0;
    queue_record(1'b1, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, '1, '0);
    for (int i = 0; i < 13; i++)
      queue_record(1'b0, 16'(i), 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                   {5{12'h7FF}}, {5{12'h800}});
    wait_drained();

    // long receiver hold while records keep coming
    write_reg(abld_pkg::REG_FRAME_WIDTH, 40);
    write_reg(abld_pkg::REG_FRAME_HEIGHT, 24);
    write_reg(abld_pkg::REG_SCORE_THRESHOLD, 16384);
    thr = 16384;
    hold_request = 300;
    queue_random(50);
    wait_drained();

    // out of range sizes clamp, highest threshold
    write_reg(abld_pkg::REG_FRAME_WIDTH, 2047);
    write_reg(abld_pkg::REG_FRAME_HEIGHT, 0);
    write_reg(abld_pkg::REG_SCORE_THRESHOLD, 65535);
    thr = 65535;
    queue_random(30);
    wait_drained();

    // shrink mid-frame without restarting the walk
    write_reg(abld_pkg::REG_FRAME_WIDTH, 1024);
    write_reg(abld_pkg::REG_FRAME_HEIGHT, 1024);
    write_reg(abld_pkg::REG_SCORE_THRESHOLD, 30000);
    thr = 30000;
    queue_record(1'b1, 16'hFFFF, '0, '0, '0, '0, '0, '0);
    queue_random(30);
    wait_drained();
    write_reg(abld_pkg::REG_FRAME_WIDTH, 16);
    write_reg(abld_pkg::REG_FRAME_HEIGHT, 9);
    queue_random(40);
    wait_drained();

    // final stretch at full rate
    write_reg(abld_pkg::REG_FRAME_WIDTH, $urandom_range(8, 64));
    write_reg(abld_pkg::REG_FRAME_HEIGHT, $urandom_range(8, 64));
    thr = $urandom_range(0, 40000);
    write_reg(abld_pkg::REG_SCORE_THRESHOLD, thr);
    quiet = 1'b1;
    queue_random(40);
    wait_drained();
    repeat (20) @(posedge clk);

    $display("decoded %0d boxes and %0d landmark points over several frame sizes",
             boxes_seen, points_seen);
    $display("thresholds 0 to 65535, clamped sizes, counter wraps and output backpressure");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
